// File: hdl/stt_pkg.sv
// Shared types and constants for the software timer table.
// Used by stt_slots, stt_scan and software_timer_table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);

  localparam int KIND_W     = 3;
  localparam int IDX_W      = 3;
  localparam int PERIOD_W   = 32;
  localparam int RKIND_W    = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_CHANGE = 3'd4,
    KIND_DELETE = 3'd5
  } kind_t;

  typedef enum logic [RKIND_W-1:0] {
    RK_ACK       = 2'd0,
    RK_EXPIRED   = 2'd1,
    RK_NO_EXPIRY = 2'd2
  } rkind_t;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_CREATE,
    SOP_ARM,
    SOP_STOP,
    SOP_SETPER,
    SOP_DELETE
  } slot_op_t;

  typedef struct packed {
    slot_op_t              op;
    logic [SLOT_W-1:0]     slot;
    logic [PERIOD_W-1:0]   period;
    logic                  ar;
  } slot_wr_t;

  typedef struct packed {
    logic              start;   // forget the best candidate of the last round
    logic              new_tick;// clear the pending set
    logic              step;    // examine one slot
    logic              first;   // first round of a tick builds the pending set
    logic [SLOT_W-1:0] slot;
    logic              drop;    // remove the current best from the pending set
  } scan_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] best;
    logic              more;    // pending timers remain besides the best
  } scan_stat_t;

endpackage

`default_nettype wire

// File: hdl/stt_slots.sv
// Timer slot state: period, expiry and flag registers with one write port.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_slots
  import stt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire slot_wr_t              wr,
  input  wire logic [TIME_BITS-1:0]  now,
  input  wire logic [SLOT_W-1:0]     rd_slot,
  output logic      [TIME_BITS-1:0]  rd_expiry,
  output logic      [NUM_TIMERS-1:0] running,
  output logic      [NUM_TIMERS-1:0] periodic,
  output logic      [NUM_TIMERS-1:0] created
);

  logic [TIME_BITS-1:0] period [NUM_TIMERS];
  logic [TIME_BITS-1:0] expiry [NUM_TIMERS];
  logic [TIME_BITS-1:0] new_period;
  logic [TIME_BITS-1:0] arm_period;
  logic [TIME_BITS-1:0] arm_expiry;

  assign new_period = TIME_BITS'(wr.period);
  assign arm_period = (wr.op == SOP_SETPER) ? new_period : period[wr.slot];
  assign arm_expiry = now + arm_period;
  assign rd_expiry  = expiry[rd_slot];

  always_ff @(posedge clk) begin
    case (wr.op)
      SOP_CREATE: period[wr.slot] <= new_period;
      SOP_ARM: expiry[wr.slot] <= arm_expiry;
      SOP_SETPER: begin
        period[wr.slot] <= new_period;
        expiry[wr.slot] <= arm_expiry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= '0;
      periodic <= '0;
      created  <= '0;
    end else begin
      case (wr.op)
        SOP_CREATE: begin
          created[wr.slot]  <= 1'b1;
          periodic[wr.slot] <= wr.ar;
          running[wr.slot]  <= 1'b0;
        end
        SOP_ARM, SOP_SETPER: running[wr.slot] <= 1'b1;
        SOP_STOP: running[wr.slot] <= 1'b0;
        SOP_DELETE: begin
          created[wr.slot]  <= 1'b0;
          periodic[wr.slot] <= 1'b0;
          running[wr.slot]  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/stt_scan.sv
// Expiry scan unit: one subtract and compare per cycle, keeps the most
// overdue pending timer and the pending set of the current tick. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_scan
  import stt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scan_ctrl_t            ctrl,
  input  wire logic [TIME_BITS-1:0]  now,
  input  wire logic [TIME_BITS-1:0]  expiry,
  input  wire logic [NUM_TIMERS-1:0] running,
  output scan_stat_t                 stat
);

  logic [NUM_TIMERS-1:0] pend;
  logic [NUM_TIMERS-1:0] pend_after;
  logic [TIME_BITS-1:0]  best_late;
  logic [SLOT_W-1:0]     best;
  logic                  found;
  logic [TIME_BITS-1:0]  late;
  logic                  reached;
  logic                  cand;
  logic                  better;

  assign late    = now - expiry;
  assign reached = ~late[TIME_BITS-1];
  assign cand    = ctrl.first ? (running[ctrl.slot] & reached) : pend[ctrl.slot];
  // strict compare: on a tie the lower slot, seen first, keeps the place
  assign better  = ~found | (late > best_late);

  always_comb begin
    pend_after       = pend;
    pend_after[best] = 1'b0;
  end

  assign stat.found = found;
  assign stat.best  = best;
  assign stat.more  = |pend_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      found <= 1'b0;
    end else begin
      if (ctrl.drop) begin
        pend <= pend_after;
      end
      if (ctrl.new_tick) begin
        pend <= '0;
      end
      if (ctrl.start) begin
        found <= 1'b0;
      end else if (ctrl.step) begin
        if (ctrl.first) begin
          pend[ctrl.slot] <= cand;
        end
        if (cand && better) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && !ctrl.start && cand && better) begin
      best      <= ctrl.slot;
      best_late <= late;
    end
  end

endmodule

`default_nettype wire

// File: hdl/software_timer_table.sv
// Software timer table top level: command decode, tick sequencer, result register.
// Depends on stt_pkg, stt_slots and stt_scan.
`timescale 1ns / 1ps
`default_nettype none

// A command (create, start, stop, change period, delete) is registered,
// then decoded in ST_CMD, and gives one acknowledgement. A tick advances
// the time counter and then runs one scan round per fired timer (at least
// one, at most MAX_RESULTS): each round walks all NUM_TIMERS slots through
// a single subtract-and-compare unit, one slot a cycle, and ST_DECIDE then
// issues the result once the output register is free. Input
// is taken only between items; the result register lets the last result
// wait on the output while the next item is accepted.

module software_timer_table
  import stt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // timer_index [2:0], period [34:3], auto_reload [35], zero [39:36]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [2:0]
  input  wire logic [KIND_W-1:0]     s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // timer_index_res [2:0], status [3], zero [7:4]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind [1:0]
  output logic      [RKIND_W-1:0]    m_axis_tuser,
  output logic                       m_axis_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_CMD, ST_SCAN, ST_DECIDE} state_t;

  state_t                state;
  logic [KIND_W-1:0]     kind_q;
  logic [IDX_W-1:0]      idx_q;
  logic [PERIOD_W-1:0]   period_q;
  logic                  ar_q;
  logic [TIME_BITS-1:0]  now;
  logic [SLOT_W-1:0]     cnt;
  logic [RES_W-1:0]      nres;
  logic                  first;

  logic                  out_free;
  logic                  out_load;
  logic                  in_accept;
  logic [SLOT_W-1:0]     cmd_slot;
  logic                  idx_ok;
  logic                  known;
  logic                  cmd_status;
  slot_op_t              cmd_op;
  logic                  last_fire;

  slot_wr_t              slot_wr;
  scan_ctrl_t            scan_ctrl;
  scan_stat_t            scan_stat;
  logic [TIME_BITS-1:0]  rd_expiry;
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] periodic;
  logic [NUM_TIMERS-1:0] created;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && (state == ST_CMD || state == ST_DECIDE);

  // command decode
  assign cmd_slot = SLOT_W'(idx_q);
  assign idx_ok   = (32'(idx_q) < NUM_TIMERS);
  assign known    = (kind_q <= KIND_DELETE);

  always_comb begin
    cmd_status = 1'b0;
    cmd_op     = SOP_NONE;
    if (known && kind_q != KIND_TICK) begin
      if (!idx_ok || (kind_q != KIND_CREATE && !created[cmd_slot])) begin
        cmd_status = 1'b1;
      end else begin
        case (kind_q)
          KIND_CREATE: cmd_op = SOP_CREATE;
          KIND_START:  cmd_op = SOP_ARM;
          KIND_STOP:   cmd_op = SOP_STOP;
          KIND_CHANGE: cmd_op = SOP_SETPER;
          KIND_DELETE: cmd_op = SOP_DELETE;
          default:     cmd_op = SOP_NONE;
        endcase
      end
    end
  end

  assign last_fire = !scan_stat.more || (nres == RES_W'(MAX_RESULTS - 1));

  always_comb begin
    slot_wr.op     = SOP_NONE;
    slot_wr.slot   = cmd_slot;
    slot_wr.period = period_q;
    slot_wr.ar     = ar_q;
    if (state == ST_CMD && out_free) begin
      slot_wr.op = cmd_op;
    end else if (state == ST_DECIDE && out_free && scan_stat.found) begin
      // one-shot stops, auto-reload rearms at now plus period
      slot_wr.slot = scan_stat.best;
      slot_wr.op   = periodic[scan_stat.best] ? SOP_ARM : SOP_STOP;
    end
  end

  always_comb begin
    scan_ctrl.new_tick = in_accept && (s_axis_tuser == KIND_TICK);
    scan_ctrl.step     = (state == ST_SCAN);
    scan_ctrl.first    = first;
    scan_ctrl.slot     = cnt;
    scan_ctrl.drop     = (state == ST_DECIDE) && out_free && scan_stat.found;
    scan_ctrl.start    = scan_ctrl.new_tick || scan_ctrl.drop;
  end

  stt_slots u_slots (
    .clk       (clk),
    .rst       (rst),
    .wr        (slot_wr),
    .now       (now),
    .rd_slot   (cnt),
    .rd_expiry (rd_expiry),
    .running   (running),
    .periodic  (periodic),
    .created   (created)
  );

  stt_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (scan_ctrl),
    .now     (now),
    .expiry  (rd_expiry),
    .running (running),
    .stat    (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      now           <= '0;
      cnt           <= '0;
      nres          <= '0;
      first         <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q   <= s_axis_tuser;
            idx_q    <= s_axis_tdata[IDX_W-1:0];
            period_q <= s_axis_tdata[IDX_W +: PERIOD_W];
            ar_q     <= s_axis_tdata[IDX_W + PERIOD_W];
            if (s_axis_tuser == KIND_TICK) begin
              now   <= now + TIME_BITS'(1);
              cnt   <= '0;
              nres  <= '0;
              first <= 1'b1;
              state <= ST_SCAN;
            end else begin
              state <= ST_CMD;
            end
          end
        end
        ST_CMD: begin
          if (out_free) begin
            m_axis_tuser  <= RK_ACK;
            m_axis_tdata  <= {{(OUT_DATA_W - IDX_W - 1){1'b0}}, cmd_status, idx_q};
            m_axis_tlast  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + SLOT_W'(1);
          if (cnt == SLOT_W'(NUM_TIMERS - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            if (scan_stat.found) begin
              m_axis_tuser <= RK_EXPIRED;
              m_axis_tdata <= {{(OUT_DATA_W - IDX_W - 1){1'b0}}, 1'b0,
                               IDX_W'(scan_stat.best)};
              m_axis_tlast <= last_fire;
              nres         <= nres + RES_W'(1);
              first        <= 1'b0;
              cnt          <= '0;
              state        <= last_fire ? ST_IDLE : ST_SCAN;
            end else begin
              m_axis_tuser <= RK_NO_EXPIRY;
              m_axis_tdata <= '0;
              m_axis_tlast <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for software_timer_table: directed and random ticks and commands.
// Depends on stt_pkg and software_timer_table; the timer table model lives in a local class.
`timescale 1ns / 1ps

module tb;
  import stt_pkg::*;

  typedef struct {
    rkind_t            rk;
    logic [IDX_W-1:0]  idx;
    logic              status;
    logic              last;
  } timer_event_t;

  // Timer table model and the queue of results it still owes.
  class timer_scoreboard;
    logic [TIME_BITS-1:0] now_ticks;
    logic [TIME_BITS-1:0] period_of [NUM_TIMERS];
    logic [TIME_BITS-1:0] expiry_at [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] running, periodic, created;
    timer_event_t          owed [$];
    int                    errors;

    function new();
      now_ticks = '0;
      running   = '0;
      periodic  = '0;
      created   = '0;
      errors    = 0;
      foreach (period_of[i]) begin
        period_of[i] = '0;
        expiry_at[i] = '0;
      end
    endfunction

    function void owe(rkind_t rk, logic [IDX_W-1:0] idx, logic status, logic last);
      timer_event_t e;
      e.rk     = rk;
      e.idx    = idx;
      e.status = status;
      e.last   = last;
      owed.push_back(e);
    endfunction

    function void arm(int i);
      expiry_at[i] = now_ticks + period_of[i];
      running[i]   = 1'b1;
    endfunction

    function void run_tick();
      logic [NUM_TIMERS-1:0] fired;
      logic [TIME_BITS-1:0]  late, best_late;
      int                    order [MAX_RESULTS];
      int                    n, best;
      fired = '0;
      n = 0;
      best_late = '0;
      now_ticks = now_ticks + 1'b1;
      while (n < MAX_RESULTS) begin
        best = -1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          late = now_ticks - expiry_at[i];
          // skip stopped, already fired this tick, or not yet due
          if (running[i] && !fired[i] && !late[TIME_BITS-1] &&
              (best < 0 || late > best_late)) begin
            best = i;
            best_late = late;
          end
        end
        if (best < 0) break;
        fired[best] = 1'b1;
        if (periodic[best]) arm(best);
        else running[best] = 1'b0;
        order[n] = best;
        n++;
      end
      if (n == 0) owe(RK_NO_EXPIRY, '0, 1'b0, 1'b1);
      for (int k = 0; k < n; k++) owe(RK_EXPIRED, IDX_W'(order[k]), 1'b0, k == n - 1);
    endfunction

    function void note_item(kind_t kind, logic [IDX_W-1:0] idx,
                            logic [PERIOD_W-1:0] per, logic ar);
      if (kind == KIND_TICK) begin
        run_tick();
      end else if (kind > KIND_DELETE) begin
        // unknown kind: acknowledge, change nothing
        owe(RK_ACK, idx, 1'b0, 1'b1);
      end else if (kind == KIND_CREATE) begin
        created[idx]   = 1'b1;
        periodic[idx]  = ar;
        running[idx]   = 1'b0;
        period_of[idx] = per;
        owe(RK_ACK, idx, 1'b0, 1'b1);
      end else if (!created[idx]) begin
        owe(RK_ACK, idx, 1'b1, 1'b1);
      end else begin
        case (kind)
          KIND_START: arm(idx);
          KIND_STOP: running[idx] = 1'b0;
          KIND_CHANGE: begin
            period_of[idx] = per;
            arm(idx);
          end
          KIND_DELETE: begin
            created[idx]  = 1'b0;
            running[idx]  = 1'b0;
            periodic[idx] = 1'b0;
          end
          default: ;
        endcase
        owe(RK_ACK, idx, 1'b0, 1'b1);
      end
    endfunction

    function void check_result(rkind_t rk, logic [IDX_W-1:0] idx, logic status, logic last);
      timer_event_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result kind=%0d idx=%0d status=%0d last=%0d",
                 $time, rk, idx, status, last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (rk !== e.rk) begin
        $display("%0t: result_kind expected %0d got %0d", $time, e.rk, rk);
        errors++;
      end
      if (idx !== e.idx) begin
        $display("%0t: timer_index_res expected %0d got %0d", $time, e.idx, idx);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, status);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0d got %0d", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [RKIND_W-1:0]    m_axis_tuser;
  logic                  m_axis_tlast;

  timer_scoreboard sb;
  bit              no_idle;
  int              hold_left;

  software_timer_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Note accepted items first so that results of the same edge find their entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(kind_t'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[34:3],
                     s_axis_tdata[35]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(rkind_t'(m_axis_tuser), m_axis_tdata[2:0], m_axis_tdata[3],
                        m_axis_tlast);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(kind_t kind, logic [IDX_W-1:0] idx,
                           logic [PERIOD_W-1:0] per, logic ar);
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, ar, per, idx};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_random();
    int                  roll;
    logic [PERIOD_W-1:0] per;
    kind_t               kind;
    roll = $urandom_range(0, 99);
    if (roll < 46) kind = KIND_TICK;
    else if (roll < 58) kind = KIND_CREATE;
    else if (roll < 78) kind = KIND_START;
    else if (roll < 85) kind = KIND_STOP;
    else if (roll < 95) kind = KIND_CHANGE;
    else kind = KIND_DELETE;
    roll = $urandom_range(0, 99);
    // mostly short periods so timers fire within a few ticks
    if (roll < 85) per = $urandom_range(0, 12);
    else if (roll < 92) per = 32'h8000_0000 + $urandom_range(0, 3) - 2;
    else per = $urandom;
    send_item(kind, IDX_W'($urandom_range(0, NUM_TIMERS - 1)), per,
              1'($urandom_range(0, 1)));
  endtask

  // Drop the offer, then hold until every owed result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    hold_left = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(KIND_TICK, 3'd6, 32'd0, 1'b0);
    send_item(KIND_STOP, 3'd3, 32'd0, 1'b0);           // slot never created
    send_item(KIND_CREATE, 3'd0, 32'd0, 1'b1);         // periodic, zero period
    send_item(KIND_CREATE, 3'd7, 32'hFFFF_FFFF, 1'b0); // wraps to already overdue
    send_item(KIND_CREATE, 3'd5, 32'd2, 1'b0);
    send_item(KIND_START, 3'd0, 32'd0, 1'b0);
    send_item(KIND_START, 3'd7, 32'd0, 1'b0);
    send_item(KIND_START, 3'd5, 32'd0, 1'b0);
    send_item(KIND_TICK, 3'd0, 32'd0, 1'b0);           // most overdue fires first
    send_item(KIND_TICK, 3'd0, 32'd0, 1'b0);
    send_item(KIND_CREATE, 3'd2, 32'd1, 1'b1);
    send_item(KIND_CREATE, 3'd3, 32'd1, 1'b1);
    send_item(KIND_START, 3'd3, 32'd0, 1'b0);
    send_item(KIND_START, 3'd2, 32'd0, 1'b0);
    send_item(KIND_TICK, 3'd0, 32'd0, 1'b0);           // equal lateness: lower index first
    send_item(KIND_CHANGE, 3'd5, 32'h8000_0000, 1'b0); // half range ahead: not reached
    send_item(KIND_START, 3'd2, 32'd0, 1'b0);          // restart a running timer
    send_item(KIND_CREATE, 3'd3, 32'h5555_5555, 1'b0); // re-create stops the slot
    send_item(KIND_DELETE, 3'd7, 32'd0, 1'b0);
    send_item(KIND_START, 3'd7, 32'd0, 1'b0);
    send_item(KIND_CHANGE, 3'd7, 32'd3, 1'b1);
    send_item(KIND_DELETE, 3'd7, 32'd0, 1'b0);
    send_item(KIND_STOP, 3'd0, 32'd0, 1'b0);
    send_item(KIND_TICK, 3'd0, 32'd0, 1'b0);
    send_item(KIND_CREATE, 3'd4, 32'hAAAA_AAAA, 1'b1);

    for (int n = 0; n < 255; n++) begin
      if (n == 60) hold_left = 400;   // back up the output while items keep coming
      if (n == 120) wait_drained();
      no_idle = (n >= 150 && n < 200);
      send_random();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
